FILE: hw/rtl/assert_macros.svh
// Assertion macros shared by the scanline run midpoint detector modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every clock edge out of reset.
`define SRMD_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define SRMD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Condition that must never hold.
`define SRMD_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error(msg);

`endif

FILE: hw/rtl/srmd_pkg.sv
// Shared constants and types of the scanline run midpoint detector.
package srmd_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;

  localparam int PIX_W     = 8;
  localparam int CFG_W     = 11;
  localparam int STEP_W    = 5;
  localparam int COORD_W   = 10;
  localparam int COL_IDX_W = $clog2(MAX_WIDTH);
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SCAN_STEP    = 2'd2;

  localparam logic [CFG_W-1:0]  RST_FRAME_WIDTH  = 11'd640;
  localparam logic [CFG_W-1:0]  RST_FRAME_HEIGHT = 11'd480;
  localparam logic [STEP_W-1:0] RST_SCAN_STEP    = 5'd5;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Effective geometry after clamping.
  typedef struct packed {
    logic [CFG_W-1:0]  width;
    logic [CFG_W-1:0]  height;
    logic [STEP_W-1:0] step;
  } cfg_t;

  // Points caused by one pixel: horizontal at (row, h_col), vertical at (v_row, col).
  typedef struct packed {
    logic               h_valid;
    logic               v_valid;
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] h_col;
    logic [COORD_W-1:0] v_row;
  } point_rec_t;

endpackage

FILE: hw/rtl/srmd_rem.sv
// Bit-serial remainder of a coordinate by the scan step.
module srmd_rem (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [srmd_pkg::COORD_W-1:0]  dividend,
  input  logic [srmd_pkg::STEP_W-1:0]   divisor,
  output logic                          busy,
  output logic                          done,
  output logic [srmd_pkg::STEP_W-1:0]   remainder
);

  localparam int CNT_W = $clog2(srmd_pkg::COORD_W);

  logic                         busy_r, busy_nxt;
  logic                         done_r, done_nxt;
  logic [CNT_W-1:0]             cnt_r, cnt_nxt;
  logic [srmd_pkg::COORD_W-1:0] dvd_r, dvd_nxt;
  logic [srmd_pkg::STEP_W-1:0]  dsr_r, dsr_nxt;
  logic [srmd_pkg::STEP_W-1:0]  rem_r, rem_nxt;
  logic [srmd_pkg::STEP_W:0]    trial;
  logic [srmd_pkg::STEP_W:0]    diff;
  logic [srmd_pkg::STEP_W:0]    sel;

  assign trial = {rem_r, dvd_r[srmd_pkg::COORD_W-1]};
  assign diff  = trial - {1'b0, dsr_r};
  assign sel   = (trial >= {1'b0, dsr_r}) ? diff : trial;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    dvd_nxt  = dvd_r;
    dsr_nxt  = dsr_r;
    rem_nxt  = rem_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(srmd_pkg::COORD_W - 1);
      dvd_nxt  = dividend;
      dsr_nxt  = divisor;
      rem_nxt  = '0;
    end else if (busy_r) begin
      // one dividend bit per cycle, restoring
      rem_nxt = sel[srmd_pkg::STEP_W-1:0];
      dvd_nxt = {dvd_r[srmd_pkg::COORD_W-2:0], 1'b0};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r <= cnt_nxt;
    dvd_r <= dvd_nxt;
    dsr_r <= dsr_nxt;
    rem_r <= rem_nxt;
  end

  assign busy      = busy_r;
  assign done      = done_r;
  assign remainder = rem_r;

endmodule

FILE: hw/rtl/srmd_fifo.sv
// Short queue of point records between the front and back ends.
`include "assert_macros.svh"

module srmd_fifo (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         push,
  input  srmd_pkg::point_rec_t         push_rec,
  input  logic                         pop,
  output srmd_pkg::point_rec_t         head,
  output logic                         empty,
  output logic [srmd_pkg::QCNT_W-1:0]  count
);

  srmd_pkg::point_rec_t          slot_r [srmd_pkg::QUEUE_DEPTH];
  logic [srmd_pkg::QPTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [srmd_pkg::QPTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [srmd_pkg::QCNT_W-1:0]   count_r, count_nxt;
  logic                          do_pop;

  assign do_pop = pop && (count_r != '0);

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (!push && do_pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
    if (push) begin
      slot_r[wr_ptr_r] <= push_rec;
    end
  end

  assign head  = slot_r[rd_ptr_r];
  assign empty = (count_r == '0);
  assign count = count_r;

  `SRMD_ASSERT_NEVER(fifo_no_overflow, push && !do_pop && (count_r == srmd_pkg::QCNT_W'(srmd_pkg::QUEUE_DEPTH)), "point queue overflow")

endmodule

FILE: hw/rtl/srmd_front.sv
// Front end: pixel position, run tracking, column run memory, record build.
`include "assert_macros.svh"

module srmd_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  srmd_pkg::cfg_t                cfg,
  input  logic                          step_wr,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [srmd_pkg::PIX_W-1:0]    in_pixel_level,
  input  logic [srmd_pkg::QCNT_W-1:0]   q_count,
  output logic                          q_push,
  output srmd_pkg::point_rec_t          q_rec
);

  typedef struct packed {
    logic                         open;
    logic [srmd_pkg::COORD_W-1:0] start;
  } col_entry_t;

  // column run memory: read at accept, written in the cycle after
  col_entry_t col_mem [srmd_pkg::MAX_WIDTH];

  logic                            clr_busy_r, clr_busy_nxt;
  logic [srmd_pkg::COL_IDX_W-1:0]  clr_addr_r, clr_addr_nxt;
  logic                            pend_r;

  logic [srmd_pkg::COORD_W-1:0]    cur_row_r, cur_row_nxt;
  logic [srmd_pkg::COORD_W-1:0]    cur_col_r, cur_col_nxt;
  logic [srmd_pkg::STEP_W-1:0]     row_phase_r, row_phase_nxt;
  logic [srmd_pkg::STEP_W-1:0]     col_phase_r, col_phase_nxt;
  logic                            row_open_r, row_open_nxt;
  logic [srmd_pkg::COORD_W-1:0]    row_start_r, row_start_nxt;

  logic                            b_valid_r;
  logic                            b_white_r;
  logic [srmd_pkg::COORD_W-1:0]    b_row_r;
  logic [srmd_pkg::COORD_W-1:0]    b_col_r;
  logic                            b_col_scan_r;
  logic                            b_h_hit_r;
  logic [srmd_pkg::COORD_W-1:0]    b_h_col_r;

  col_entry_t                      mem_q_r;
  logic                            byp_r;
  col_entry_t                      byp_d_r;

  logic                            rem_busy, rem_done, rem_busy_c, rem_done_c;
  logic [srmd_pkg::STEP_W-1:0]     row_rem, col_rem;

  logic                            q_full;
  logic                            a_fire;
  logic                            white;
  logic                            row_scan, col_scan;
  logic                            col_wrap, row_wrap;
  logic                            h_hit;
  logic [srmd_pkg::COORD_W:0]      h_sum;

  col_entry_t                      b_ent;
  logic                            b_open;
  logic                            v_hit;
  logic                            b_we;
  col_entry_t                      b_wdata;
  logic [srmd_pkg::COORD_W:0]      v_sum;

  logic                            mem_we;
  logic [srmd_pkg::COL_IDX_W-1:0]  mem_waddr;
  col_entry_t                      mem_wdata;

  srmd_rem u_rem_row (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (pend_r),
    .dividend  (cur_row_r),
    .divisor   (cfg.step),
    .busy      (rem_busy),
    .done      (rem_done),
    .remainder (row_rem)
  );

  srmd_rem u_rem_col (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (pend_r),
    .dividend  (cur_col_r),
    .divisor   (cfg.step),
    .busy      (rem_busy_c),
    .done      (rem_done_c),
    .remainder (col_rem)
  );

  // leave room for the record still in the second stage
  assign q_full   = ({1'b0, q_count} + (srmd_pkg::QCNT_W + 1)'(b_valid_r))
                    >= (srmd_pkg::QCNT_W + 1)'(srmd_pkg::QUEUE_DEPTH);
  assign in_stall = clr_busy_r || pend_r || rem_busy || rem_busy_c ||
                    rem_done || rem_done_c || q_full;
  assign a_fire   = in_valid && !in_stall;

  assign white    = (in_pixel_level != '0);
  assign row_scan = (row_phase_r == '0);
  assign col_scan = (col_phase_r == '0);
  assign col_wrap = ({1'b0, cur_col_r} + 11'd1) >= cfg.width;
  assign row_wrap = ({1'b0, cur_row_r} + 11'd1) >= cfg.height;
  assign h_hit    = row_scan && row_open_r && !white;
  assign h_sum    = {1'b0, row_start_r} + {1'b0, cur_col_r};

  always_comb begin
    cur_row_nxt   = cur_row_r;
    cur_col_nxt   = cur_col_r;
    row_phase_nxt = row_phase_r;
    col_phase_nxt = col_phase_r;
    row_open_nxt  = row_open_r;
    row_start_nxt = row_start_r;
    if (rem_done) begin
      row_phase_nxt = row_rem;
      col_phase_nxt = col_rem;
    end else if (a_fire) begin
      if (row_scan) begin
        if (row_open_r && !white) begin
          row_open_nxt = 1'b0;
        end else if (!row_open_r && white) begin
          row_open_nxt  = 1'b1;
          row_start_nxt = cur_col_r;
        end
      end
      if (col_wrap) begin
        // drop any open row run at the row end
        row_open_nxt  = 1'b0;
        cur_col_nxt   = '0;
        col_phase_nxt = '0;
        if (row_wrap) begin
          cur_row_nxt   = '0;
          row_phase_nxt = '0;
        end else begin
          cur_row_nxt   = cur_row_r + 1'b1;
          row_phase_nxt = (({1'b0, row_phase_r} + 6'd1) == {1'b0, cfg.step}) ?
                          '0 : row_phase_r + 1'b1;
        end
      end else begin
        cur_col_nxt   = cur_col_r + 1'b1;
        col_phase_nxt = (({1'b0, col_phase_r} + 6'd1) == {1'b0, cfg.step}) ?
                        '0 : col_phase_r + 1'b1;
      end
    end
  end

  // second stage: column run decision
  assign b_ent   = byp_r ? byp_d_r : mem_q_r;
  assign b_open  = (b_row_r != '0) && b_ent.open;
  assign v_hit   = b_valid_r && b_col_scan_r && b_open && !b_white_r;
  assign b_we    = b_valid_r && b_col_scan_r && !(b_open && b_white_r);
  assign b_wdata = '{open: b_white_r, start: b_row_r};
  assign v_sum   = {1'b0, b_ent.start} + {1'b0, b_row_r};

  assign q_push      = b_valid_r && (b_h_hit_r || v_hit);
  assign q_rec.h_valid = b_h_hit_r;
  assign q_rec.v_valid = v_hit;
  assign q_rec.row     = b_row_r;
  assign q_rec.col     = b_col_r;
  assign q_rec.h_col   = b_h_col_r;
  assign q_rec.v_row   = v_sum[srmd_pkg::COORD_W:1];

  assign mem_we    = clr_busy_r || b_we;
  assign mem_waddr = clr_busy_r ? clr_addr_r : b_col_r[srmd_pkg::COL_IDX_W-1:0];
  assign mem_wdata = clr_busy_r ? col_entry_t'('0) : b_wdata;

  always_comb begin
    clr_busy_nxt = clr_busy_r;
    clr_addr_nxt = clr_addr_r;
    if (clr_busy_r) begin
      clr_addr_nxt = clr_addr_r + 1'b1;
      if (clr_addr_r == srmd_pkg::COL_IDX_W'(srmd_pkg::MAX_WIDTH - 1)) begin
        clr_busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r  <= 1'b1;
      clr_addr_r  <= '0;
      pend_r      <= 1'b0;
      cur_row_r   <= '0;
      cur_col_r   <= '0;
      row_phase_r <= '0;
      col_phase_r <= '0;
      row_open_r  <= 1'b0;
      row_start_r <= '0;
      b_valid_r   <= 1'b0;
    end else begin
      clr_busy_r  <= clr_busy_nxt;
      clr_addr_r  <= clr_addr_nxt;
      pend_r      <= step_wr;
      cur_row_r   <= cur_row_nxt;
      cur_col_r   <= cur_col_nxt;
      row_phase_r <= row_phase_nxt;
      col_phase_r <= col_phase_nxt;
      row_open_r  <= row_open_nxt;
      row_start_r <= row_start_nxt;
      b_valid_r   <= a_fire;
    end
    if (a_fire) begin
      b_white_r    <= white;
      b_row_r      <= cur_row_r;
      b_col_r      <= cur_col_r;
      b_col_scan_r <= col_scan;
      b_h_hit_r    <= h_hit;
      b_h_col_r    <= h_sum[srmd_pkg::COORD_W:1];
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      col_mem[mem_waddr] <= mem_wdata;
    end
    if (a_fire) begin
      mem_q_r <= col_mem[cur_col_r[srmd_pkg::COL_IDX_W-1:0]];
      // forward a write to the column being read in the same cycle
      byp_r   <= b_we && (b_col_r == cur_col_r);
      byp_d_r <= b_wdata;
    end
  end

  `SRMD_ASSERT_IMPL(fr_stage_follows_accept, b_valid_r, $past(a_fire), "stage two without accept")
  `SRMD_ASSERT_NEVER(fr_accept_while_busy, a_fire && (clr_busy_r || rem_busy), "pixel taken while busy")

endmodule

FILE: hw/rtl/srmd_back.sv
// Back end: expands queued records into output points, one per cycle while out_stall is low.
`include "assert_macros.svh"

module srmd_back (
  input  logic                           clk,
  input  logic                           rst_n,
  input  srmd_pkg::point_rec_t           head,
  input  logic                           empty,
  output logic                           pop,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [srmd_pkg::COORD_W-1:0]   out_point_row,
  output logic [srmd_pkg::COORD_W-1:0]   out_point_col,
  output logic                           out_is_vertical,
  output logic                           out_last_of_item
);

  logic                          v_pend_r, v_pend_nxt;
  logic                          out_valid_r, out_valid_nxt;
  logic [srmd_pkg::COORD_W-1:0]  row_r, row_nxt;
  logic [srmd_pkg::COORD_W-1:0]  col_r, col_nxt;
  logic                          vert_r, vert_nxt;
  logic                          last_r, last_nxt;
  logic                          load;

  assign load = (!out_valid_r || !out_stall) && !empty;

  always_comb begin
    v_pend_nxt    = v_pend_r;
    out_valid_nxt = out_valid_r && out_stall;
    row_nxt       = row_r;
    col_nxt       = col_r;
    vert_nxt      = vert_r;
    last_nxt      = last_r;
    pop           = 1'b0;
    if (load) begin
      out_valid_nxt = 1'b1;
      if (!v_pend_r && head.h_valid) begin
        // horizontal point goes first
        row_nxt    = head.row;
        col_nxt    = head.h_col;
        vert_nxt   = 1'b0;
        last_nxt   = !head.v_valid;
        v_pend_nxt = head.v_valid;
        pop        = !head.v_valid;
      end else begin
        row_nxt    = head.v_row;
        col_nxt    = head.col;
        vert_nxt   = 1'b1;
        last_nxt   = 1'b1;
        v_pend_nxt = 1'b0;
        pop        = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_pend_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      v_pend_r    <= v_pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
    row_r  <= row_nxt;
    col_r  <= col_nxt;
    vert_r <= vert_nxt;
    last_r <= last_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_point_row    = row_r;
  assign out_point_col    = col_r;
  assign out_is_vertical  = vert_r;
  assign out_last_of_item = last_r;

  `SRMD_ASSERT_IMPL(bk_pending_has_head, v_pend_r, !empty, "vertical point pending on empty queue")
  `SRMD_ASSERT_NEXT(bk_h_then_v, out_valid_r && !out_stall && !last_r, out_valid_r && vert_r, "horizontal point not followed by its vertical point")

endmodule

FILE: hw/rtl/scanline_run_midpoint_detector.sv
// Top level of the scanline run midpoint detector.
//
//  channel  | handshake           | payload
//  ---------+---------------------+-------------------------------------------
//  in       | in_valid / in_stall | in_pixel_level[7:0]
//  out      | out_valid/out_stall | out_point_row, out_point_col, out_is_vertical,
//           |                     | out_last_of_item
//  cfg      | cfg_we              | cfg_index[1:0], cfg_wdata[10:0]
//
// One pixel per clock while in_stall is low; each pixel yields up to two points,
// sent one per clock while out_stall is low. A pixel's first point passes the
// column memory read stage, the point queue register and the output register.
// After reset the column run memory is cleared, all 1024 entries; in_stall is high.
// A scan_step write holds in_stall high while the row and column
// phases are recomputed by the bit-serial remainder units.
// in_stall rises when the point queue fills under out_stall.
module scanline_run_midpoint_detector (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [srmd_pkg::PIX_W-1:0]       in_pixel_level,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [srmd_pkg::COORD_W-1:0]     out_point_row,
  output logic [srmd_pkg::COORD_W-1:0]     out_point_col,
  output logic                             out_is_vertical,
  output logic                             out_last_of_item,
  input  logic                             cfg_we,
  input  logic [srmd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [srmd_pkg::CFG_W-1:0]       cfg_wdata
);

  logic [srmd_pkg::CFG_W-1:0]   width_r, width_nxt;
  logic [srmd_pkg::CFG_W-1:0]   height_r, height_nxt;
  logic [srmd_pkg::STEP_W-1:0]  step_r, step_nxt;
  logic                         step_wr;
  srmd_pkg::cfg_t               cfg;

  logic                         q_push;
  srmd_pkg::point_rec_t         q_rec;
  logic                         q_pop;
  srmd_pkg::point_rec_t         q_head;
  logic                         q_empty;
  logic [srmd_pkg::QCNT_W-1:0]  q_count;

  always_comb begin
    width_nxt  = width_r;
    height_nxt = height_r;
    step_nxt   = step_r;
    step_wr    = 1'b0;
    if (cfg_we) begin
      unique case (cfg_index)
        srmd_pkg::REG_FRAME_WIDTH:  width_nxt  = cfg_wdata;
        srmd_pkg::REG_FRAME_HEIGHT: height_nxt = cfg_wdata;
        srmd_pkg::REG_SCAN_STEP: begin
          step_nxt = cfg_wdata[srmd_pkg::STEP_W-1:0];
          step_wr  = 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= srmd_pkg::RST_FRAME_WIDTH;
      height_r <= srmd_pkg::RST_FRAME_HEIGHT;
      step_r   <= srmd_pkg::RST_SCAN_STEP;
    end else begin
      width_r  <= width_nxt;
      height_r <= height_nxt;
      step_r   <= step_nxt;
    end
  end

  // clamp geometry: zero reads as one, oversize saturates
  always_comb begin
    if (width_r == '0) begin
      cfg.width = srmd_pkg::CFG_W'(1);
    end else if (width_r > srmd_pkg::CFG_W'(srmd_pkg::MAX_WIDTH)) begin
      cfg.width = srmd_pkg::CFG_W'(srmd_pkg::MAX_WIDTH);
    end else begin
      cfg.width = width_r;
    end
    if (height_r == '0) begin
      cfg.height = srmd_pkg::CFG_W'(1);
    end else if (height_r > srmd_pkg::CFG_W'(srmd_pkg::MAX_HEIGHT)) begin
      cfg.height = srmd_pkg::CFG_W'(srmd_pkg::MAX_HEIGHT);
    end else begin
      cfg.height = height_r;
    end
    cfg.step = (step_r == '0) ? srmd_pkg::STEP_W'(1) : step_r;
  end

  srmd_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg),
    .step_wr        (step_wr),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_pixel_level (in_pixel_level),
    .q_count        (q_count),
    .q_push         (q_push),
    .q_rec          (q_rec)
  );

  srmd_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_rec (q_rec),
    .pop      (q_pop),
    .head     (q_head),
    .empty    (q_empty),
    .count    (q_count)
  );

  srmd_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .head             (q_head),
    .empty            (q_empty),
    .pop              (q_pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_point_row    (out_point_row),
    .out_point_col    (out_point_col),
    .out_is_vertical  (out_is_vertical),
    .out_last_of_item (out_last_of_item)
  );

endmodule
